// ----- rtl/bbfh_pkg.sv -----
package bbfh_pkg;

  // default geometry of the page store
  localparam int unsigned RingDepthDef = 16;
  localparam int unsigned PageBitsDef  = 16;

  // fixed field widths on the ports
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PageW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned LimitW  = 4;

  // history limit after reset
  localparam logic [LimitW-1:0] LimitRst = LimitW'(5);

  // packed result: page, status, back count, forward count, padded to bytes
  localparam int unsigned ResW    = PageW + StatusW + 2 * CountW;
  localparam int unsigned ResBytW = ((ResW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_VISIT   = 2'd0,
    CMD_BACK    = 2'd1,
    CMD_FORWARD = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_PREV = 2'd1,
    STATUS_NO_FWD  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_e;

endpackage

// ----- rtl/bounded_back_forward_history_top.sv -----
// Navigation history of page ids: a current page, a back history and a forward
// history that share one circular page store of RING_DEPTH entries. Each input
// item carries a command in tuser (visit, back, forward, query) and a page id in
// tdata; each item gives exactly one result item with the current page, a
// status (ok, no previous page, no forward page) and both history counts. After
// reset the current page is id 0 (home) and both histories are empty. A visit
// pushes the current page, clears the forward history and drops the oldest back
// entry once history_limit (capped at RING_DEPTH-1) is reached. A successful
// back or forward, unlike the other items, passes the fetch state, since the page
// it returns to comes out of the store's registered read port. The history limit
// may be written only while no item is in flight.
module bounded_back_forward_history_top #(
  parameter int unsigned RING_DEPTH = bbfh_pkg::RingDepthDef,
  parameter int unsigned PAGE_BITS  = bbfh_pkg::PageBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // history limit register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bbfh_pkg::LimitW-1:0]  cfg_data_i,
  // command items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bbfh_pkg::PageW-1:0]   s_axis_tdata,   // page_id
  input  logic [bbfh_pkg::CmdW-1:0]    s_axis_tuser,   // cmd
  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bbfh_pkg::ResBytW-1:0] m_axis_tdata    // current_page, status,
                                                       // back_count, forward_count
);
  import bbfh_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);
  localparam int unsigned CntW  = $clog2(RING_DEPTH);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0]  CntMax   = CntW'(RING_DEPTH - 1);

  state_e               state_q, state_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [PAGE_BITS-1:0] cur_id_q, cur_id_d;
  logic [CntW-1:0]      back_q, back_d;
  logic [CntW-1:0]      fwd_q, fwd_d;
  logic [LimitW-1:0]    limit_q;

  logic                 m_valid_q, m_valid_d;
  logic [PageW-1:0]     out_page_q;
  status_e              out_status_q, status_d;
  logic [CountW-1:0]    out_back_q;
  logic [CountW-1:0]    out_fwd_q;
  logic                 load_out;

  logic                 accept;
  cmd_e                 cmd;
  logic [PAGE_BITS-1:0] page_in;
  logic [SlotW-1:0]     slot_inc, slot_dec;
  logic [CntW-1:0]      lim;
  logic                 at_limit;

  logic                 ram_we;
  logic [SlotW-1:0]     ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign page_in = PAGE_BITS'(s_axis_tdata);

  // ring neighbors
  assign slot_inc = (slot_q == SlotLast) ? '0 : slot_q + SlotW'(1);
  assign slot_dec = (slot_q == '0) ? SlotLast : slot_q - SlotW'(1);

  // effective limit, never above the store size minus one
  assign lim      = (32'(limit_q) > 32'(RING_DEPTH - 1)) ? CntMax : CntW'(limit_q);
  assign at_limit = (back_q != '0) && (back_q >= lim);

  // command decode and state update
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    cur_id_d  = cur_id_q;
    back_d    = back_q;
    fwd_d     = fwd_q;
    status_d  = STATUS_OK;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = slot_dec;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_VISIT: begin
              ram_we   = 1'b1;
              slot_d   = slot_inc;
              back_d   = at_limit ? back_q : back_q + CntW'(1);
              fwd_d    = '0;
              cur_id_d = page_in;
              load_out = 1'b1;
            end
            CMD_BACK: begin
              if (back_q == '0) begin
                status_d = STATUS_NO_PREV;
                load_out = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_raddr = slot_dec;
                slot_d    = slot_dec;
                back_d    = back_q - CntW'(1);
                fwd_d     = fwd_q + CntW'(1);
                state_d   = ST_FETCH;
              end
            end
            CMD_FORWARD: begin
              if (fwd_q == '0) begin
                status_d = STATUS_NO_FWD;
                load_out = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_raddr = slot_inc;
                slot_d    = slot_inc;
                fwd_d     = fwd_q - CntW'(1);
                back_d    = back_q + CntW'(1);
                state_d   = ST_FETCH;
              end
            end
            CMD_QUERY: begin
              load_out = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // page read back from the store becomes current
        cur_id_d = ram_rdata;
        load_out = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  assign m_valid_d = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  // page store: old current page goes in at the current slot
  bbfh_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (cur_id_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      cur_id_q  <= '0;
      back_q    <= '0;
      fwd_q     <= '0;
      limit_q   <= LimitRst;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      cur_id_q  <= cur_id_d;
      back_q    <= back_d;
      fwd_q     <= fwd_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_page_q   <= PageW'(cur_id_d);
      out_status_q <= status_d;
      out_back_q   <= CountW'(back_d);
      out_fwd_q    <= CountW'(fwd_d);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ResBytW'({out_fwd_q, out_back_q, out_status_q, out_page_q});

endmodule

// ----- rtl/bbfh_ram.sv -----
module bbfh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
